// ----- rtl/bpfu_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfu_pkg
// Shared types, constants and helpers for the bit-packed field unpacker.
// ----------------------------------------------------------------------------
package bpfu_pkg;

   localparam int BUF_W       = 15;
   localparam int HELD_W      = 4;
   localparam int WIDTH_W     = 4;
   localparam int NUM_W       = 4;
   // must be a power of two
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] CSR_FIELD_WIDTH = 2'd0;
   localparam logic [1:0] CSR_FIRST_BIT   = 2'd1;
   localparam logic [1:0] CSR_ELEM_COUNT  = 2'd2;

   // one byte's worth of work for the back end
   typedef struct packed {
      logic [BUF_W-1:0]   data;
      logic [WIDTH_W-1:0] width;
      logic [NUM_W-1:0]   count;
      logic               last;
   } packet_type;

   // width register to the width in use: zero acts as one, above eight as eight
   function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] raw);
      logic [WIDTH_W-1:0] w;
      w = raw;
      if (raw == 4'd0) begin
         w = 4'd1;
      end else if (raw > 4'd8) begin
         w = 4'd8;
      end
      return w;
   endfunction

   // how many whole fields fit into the held bits, capped at eight
   function automatic logic [NUM_W-1:0] fit_count(input logic [HELD_W-1:0]  held,
                                                  input logic [WIDTH_W-1:0] w);
      logic [NUM_W-1:0] q;
      logic [7:0]       span;
      q    = 4'd0;
      span = 8'd0;
      for (int k = 1; k <= 8; k++) begin
         span = {4'd0, w} * 8'(k);
         if (span <= {4'd0, held}) begin
            q = 4'(k);
         end
      end
      return q;
   endfunction

   function automatic logic [7:0] field_mask(input logic [WIDTH_W-1:0] w);
      logic [8:0] m;
      m = (9'd1 << w) - 9'd1;
      return m[7:0];
   endfunction

endpackage

// ----- rtl/bpfu_front.sv -----
// ----------------------------------------------------------------------------
// bpfu_front
// Takes source bytes, keeps the bit buffer and element count, and hands each
// byte's batch of fields to the queue.
// ----------------------------------------------------------------------------
module bpfu_front #(
   parameter int COUNT_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_src_byte,
   input  logic                        req_job_start,
   input  logic [3:0]                  field_width,
   input  logic [2:0]                  first_bit_offset,
   input  logic [31:0]                 element_count,
   input  logic                        q_full,
   output logic                        q_push,
   output bpfu_pkg::packet_type        q_packet
);

   logic [bpfu_pkg::BUF_W-1:0]   buf_ff, buf_in, buf_load;
   logic [bpfu_pkg::HELD_W-1:0]  held_ff, held_in, held_load;
   logic [COUNT_BITS-1:0]        left_ff, left_in, left_load, left_after;
   logic [bpfu_pkg::WIDTH_W-1:0] width_eff;
   logic [2:0]                   skip;
   logic [bpfu_pkg::NUM_W-1:0]   fit, num;
   logic [7:0]                   used_full;
   logic [bpfu_pkg::HELD_W-1:0]  used;
   logic                         active, take;

   assign req_ready = !q_full;

   always_comb begin
      width_eff = bpfu_pkg::eff_width(field_width);
      skip      = (width_eff == 4'd8) ? 3'd0 : first_bit_offset;
      active    = req_job_start || (left_ff != '0);

      if (req_job_start) begin
         buf_load  = {7'd0, req_src_byte >> skip};
         held_load = 4'd8 - {1'b0, skip};
         left_load = element_count[COUNT_BITS-1:0];
      end else begin
         // new byte goes in above the bits already held
         buf_load  = buf_ff | ({7'd0, req_src_byte} << held_ff);
         held_load = held_ff + 4'd8;
         left_load = left_ff;
      end

      fit       = bpfu_pkg::fit_count(held_load, width_eff);
      num       = (left_load < COUNT_BITS'(fit)) ? left_load[3:0] : fit;
      used_full = {4'd0, num} * {4'd0, width_eff};
      used      = used_full[3:0];
      left_after = left_load - COUNT_BITS'(num);

      take   = req_valid && req_ready && active;
      q_push = take && (num != 4'd0);

      q_packet.data  = buf_load;
      q_packet.width = width_eff;
      q_packet.count = num;
      q_packet.last  = (left_after == '0);

      buf_in  = buf_ff;
      held_in = held_ff;
      left_in = left_ff;
      if (take) begin
         buf_in  = buf_load >> used;
         held_in = held_load - used;
         left_in = left_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff  <= '0;
         held_ff <= '0;
         left_ff <= '0;
      end else begin
         buf_ff  <= buf_in;
         held_ff <= held_in;
         left_ff <= left_in;
      end
   end

endmodule

// ----- rtl/bpfu_queue.sv -----
// ----------------------------------------------------------------------------
// bpfu_queue
// Short first-in first-out store of batches between front and back end.
// ----------------------------------------------------------------------------
module bpfu_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bpfu_pkg::packet_type push_packet,
   input  logic                 pop,
   output logic                 head_valid,
   output bpfu_pkg::packet_type head_packet,
   output logic                 full
);

   localparam int DEPTH = bpfu_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   bpfu_pkg::packet_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   always_comb begin
      full        = (fill_ff == (PTR_W+1)'(DEPTH));
      head_valid  = (fill_ff != '0);
      head_packet = slots_ff[rd_ptr_ff];
      do_push     = push && !full;
      do_pop      = pop && head_valid;
      wr_ptr_in   = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in   = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in     = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_packet;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- rtl/bpfu_back.sv -----
// ----------------------------------------------------------------------------
// bpfu_back
// Pulls batches from the queue and sends out one field per cycle, while
// rsp_ready is high, through an output register.
// ----------------------------------------------------------------------------
module bpfu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  bpfu_pkg::packet_type head_packet,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_element,
   output logic                 rsp_last_element
);

   logic                         cur_valid_ff, cur_valid_in;
   logic [bpfu_pkg::BUF_W-1:0]   cur_data_ff, cur_data_in;
   logic [bpfu_pkg::WIDTH_W-1:0] cur_width_ff, cur_width_in;
   logic [bpfu_pkg::NUM_W-1:0]   cur_left_ff, cur_left_in;
   logic                         cur_last_ff, cur_last_in;
   logic                         out_valid_ff, out_valid_in;
   logic [7:0]                   out_element_ff, out_element_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_free, emit, cur_done;

   always_comb begin
      out_free = !out_valid_ff || rsp_ready;
      emit     = cur_valid_ff && out_free;
      cur_done = emit && (cur_left_ff == 4'd1);
      pop      = head_valid && (!cur_valid_ff || cur_done);

      cur_valid_in = cur_valid_ff;
      cur_data_in  = cur_data_ff;
      cur_width_in = cur_width_ff;
      cur_left_in  = cur_left_ff;
      cur_last_in  = cur_last_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_data_in  = head_packet.data;
         cur_width_in = head_packet.width;
         cur_left_in  = head_packet.count;
         cur_last_in  = head_packet.last;
      end else if (emit) begin
         cur_valid_in = !cur_done;
         cur_data_in  = cur_data_ff >> cur_width_ff;
         cur_left_in  = cur_left_ff - 4'd1;
      end

      out_valid_in   = out_valid_ff;
      out_element_in = out_element_ff;
      out_last_in    = out_last_ff;
      if (emit) begin
         out_valid_in   = 1'b1;
         out_element_in = cur_data_ff[7:0] & bpfu_pkg::field_mask(cur_width_ff);
         // only the final field of the final batch carries the flag
         out_last_in    = cur_last_ff && (cur_left_ff == 4'd1);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_data_ff    <= cur_data_in;
      cur_width_ff   <= cur_width_in;
      cur_left_ff    <= cur_left_in;
      cur_last_ff    <= cur_last_in;
      out_element_ff <= out_element_in;
      out_last_ff    <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_element      = out_element_ff;
   assign rsp_last_element = out_last_ff;

endmodule

// ----- rtl/bit_packed_field_unpacker.sv -----
// Path: a taken item's batch passes the queue, the current-batch register and the output register.
// Throughput: one item per cycle in while the 4-deep batch queue has room;
// out, one element per cycle while rsp_ready is high, and an item yields up
// to 8 elements at field width 1.
// Reset: synchronous, clears buffer, counters, queue and output valid; the
// registers return to width 1, offset 0, count 1.
// ----------------------------------------------------------------------------
// bit_packed_field_unpacker
// Unpacks LSB-first packed fields of 1 to 8 bits into zero-extended bytes.
// ----------------------------------------------------------------------------
module bit_packed_field_unpacker #(
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_src_byte,
   input  logic        req_job_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_element,
   output logic        rsp_last_element,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [3:0]           field_width_ff, field_width_in;
   logic [2:0]           first_bit_ff, first_bit_in;
   logic [31:0]          elem_count_ff, elem_count_in;
   logic                 q_push, q_pop, q_valid, q_full;
   bpfu_pkg::packet_type q_in_packet, q_head_packet;

   assign csr_ready = 1'b1;

   always_comb begin
      field_width_in = field_width_ff;
      first_bit_in   = first_bit_ff;
      elem_count_in  = elem_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bpfu_pkg::CSR_FIELD_WIDTH: field_width_in = csr_wdata[3:0];
            bpfu_pkg::CSR_FIRST_BIT:   first_bit_in   = csr_wdata[2:0];
            bpfu_pkg::CSR_ELEM_COUNT:  elem_count_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= 4'd1;
         first_bit_ff   <= 3'd0;
         elem_count_ff  <= 32'd1;
      end else begin
         field_width_ff <= field_width_in;
         first_bit_ff   <= first_bit_in;
         elem_count_ff  <= elem_count_in;
      end
   end

   bpfu_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_byte     (req_src_byte),
      .req_job_start    (req_job_start),
      .field_width      (field_width_ff),
      .first_bit_offset (first_bit_ff),
      .element_count    (elem_count_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_packet         (q_in_packet)
   );

   bpfu_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_packet (q_in_packet),
      .pop         (q_pop),
      .head_valid  (q_valid),
      .head_packet (q_head_packet),
      .full        (q_full)
   );

   bpfu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_valid),
      .head_packet      (q_head_packet),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_element      (rsp_element),
      .rsp_last_element (rsp_last_element)
   );

   // the front never pushes into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("batch pushed into full queue");

   // the back end only pops a batch that is there
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // empty batches never enter the queue, and no batch holds more than eight fields
   a_batch_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_in_packet.count != 4'd0) && (q_in_packet.count <= 4'd8))
      else $error("bad batch size");

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
